// File: src/rbs_pkg.sv
package rbs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_WIDTH - 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAR_THR   = 2'd2;

    localparam int THR_W = 16;

endpackage

// File: src/rbs_div.sv
// Pipelined signed divide: sat((num << FB) / den), truncated toward zero.
// One quotient bit per stage, NW + FB stages deep.
module rbs_div #(
    parameter int CW = rbs_pkg::COORD_WIDTH,
    parameter int FB = rbs_pkg::FRAC_BITS,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW+1:0] i_num,
    input  logic signed [CW-1:0] i_den,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_quot,
    output logic [TW-1:0]        o_tag
);
    localparam int NW = CW + 2;
    localparam int QW = NW + FB;
    localparam int DW = CW;
    localparam int NS = QW;

    logic [NS:0]          r_vld;
    logic [QW-1:0]        r_num [NS+1];
    logic [DW:0]          r_rem [NS+1];
    logic [DW-1:0]        r_den [NS+1];
    logic                 r_neg [NS+1];
    logic [TW-1:0]        r_tag [NS+1];

    logic [NW-1:0] n_mag;
    logic [DW-1:0] n_dmag;
    always_comb begin
        n_mag  = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_dmag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else          r_vld[0] <= i_valid;
        r_num[0] <= {n_mag, {FB{1'b0}}};
        r_rem[0] <= '0;
        r_den[0] <= n_dmag;
        r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
        r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [DW+1:0] n_sh;
        logic [DW+1:0] n_df;
        logic          n_ge;
        always_comb begin
            n_sh = {r_rem[s], r_num[s][QW-1]};
            n_df = n_sh - {2'b00, r_den[s]};
            n_ge = !n_df[DW+1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[s+1] <= 1'b0;
            else          r_vld[s+1] <= r_vld[s];
            r_rem[s+1] <= n_ge ? n_df[DW:0] : n_sh[DW:0];
            r_num[s+1] <= {r_num[s][QW-2:0], n_ge};
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            r_tag[s+1] <= r_tag[s];
        end
    end

    localparam logic [QW-1:0] SIGN_MAG = QW'(1) << (CW - 1);
    logic [QW-1:0] n_q;
    always_comb begin
        n_q = (r_num[NS] > SIGN_MAG) ? SIGN_MAG : r_num[NS];
        if (r_neg[NS]) o_quot = CW'(-n_q);
        else if (n_q == SIGN_MAG) o_quot = {1'b0, {(CW-1){1'b1}}};
        else o_quot = CW'(n_q);
    end
    assign o_valid = r_vld[NS];
    assign o_tag   = r_tag[NS];
endmodule

// File: src/ray_box_slab_intersection.sv
// Ray versus axis-aligned box slab test, signed fixed point. One request
// is taken every cycle (busy stays low); the result appears with o_valid
// high for one cycle, in request order, after the request register, the
// bit-serial divider pipelines (COORD_WIDTH + 2 + FRAC_BITS stages),
// slab ordering, interval narrowing and the point multiply stages.
// The receiver cannot stall.
module ray_box_slab_intersection #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-2:0]       i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic [COORD_WIDTH-2:0]       i_extent_x,
    input  logic [COORD_WIDTH-2:0]       i_extent_y,
    input  logic [COORD_WIDTH-2:0]       i_extent_z,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_WIDTH-1:0] o_entry_distance,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z
);
    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int TH = rbs_pkg::THR_W;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    // tag: origins and dirs (6*CW), parallel flags (3), parallel miss (1)
    localparam int TW = 6 * CW + 4;

    assign busy = 1'b0;

    logic          r_line_mode;
    logic [CW-2:0] r_max_dist;
    logic [TH-1:0] r_par_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
            r_max_dist  <= '1;
            r_par_thr   <= TH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbs_pkg::REG_LINE_MODE: r_line_mode <= i_cfg_data[0];
                rbs_pkg::REG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                rbs_pkg::REG_PAR_THR:   r_par_thr   <= TH'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage 0: register request, parallel tests, numerators
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic [CW-2:0]        ext [3];
    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign ext = '{i_extent_x, i_extent_y, i_extent_z};

    logic                 r0_vld;
    logic signed [CW-1:0] r0_org [3];
    logic signed [CW-1:0] r0_dir [3];
    logic [2:0]           r0_par;
    logic                 r0_pmiss;
    logic signed [CW+1:0] r0_n1 [3];
    logic signed [CW+1:0] r0_n2 [3];

    logic [2:0] n_par;
    logic       n_pmiss;
    always_comb begin
        logic [CW:0] m;
        logic signed [CW+1:0] o, e;
        n_pmiss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            m = dir[a][CW-1] ? (CW+1)'(-{dir[a][CW-1], dir[a]})
                             : (CW+1)'({dir[a][CW-1], dir[a]});
            n_par[a] = (dir[a] == '0) || (m < (CW+1)'(r_par_thr));
            o = (CW+2)'(org[a]);
            e = (CW+2)'({1'b0, ext[a]});
            if (n_par[a] && (o < -e || o > e)) n_pmiss = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_vld <= 1'b0;
        else          r0_vld <= start;
        r0_par   <= n_par;
        r0_pmiss <= n_pmiss;
        for (int a = 0; a < 3; a++) begin
            r0_org[a] <= org[a];
            r0_dir[a] <= dir[a];
            r0_n1[a]  <= -(CW+2)'({1'b0, ext[a]}) - (CW+2)'(org[a]);
            r0_n2[a]  <= (CW+2)'({1'b0, ext[a]}) - (CW+2)'(org[a]);
        end
    end

    logic [TW-1:0] tag_in;
    assign tag_in = {r0_org[0], r0_org[1], r0_org[2],
                     r0_dir[0], r0_dir[1], r0_dir[2], r0_par, r0_pmiss};

    logic                 d_vld [6];
    logic signed [CW-1:0] d_q   [6];
    logic [TW-1:0]        d_tag [6];
    for (genvar k = 0; k < 6; k++) begin : g_div
        rbs_div #(.CW(CW), .FB(FB), .TW(TW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r0_vld),
            .i_num   ((k % 2 == 0) ? r0_n1[k/2] : r0_n2[k/2]),
            .i_den   (r0_dir[k/2]),
            .i_tag   (tag_in),
            .o_valid (d_vld[k]),
            .o_quot  (d_q[k]),
            .o_tag   (d_tag[k])
        );
    end

    logic signed [CW-1:0] t_org [3];
    logic signed [CW-1:0] t_dir [3];
    logic [2:0]           t_par;
    logic                 t_pmiss;
    assign {t_org[0], t_org[1], t_org[2], t_dir[0], t_dir[1], t_dir[2],
            t_par, t_pmiss} = d_tag[0];

    // stage A: order slab distances
    logic                 ra_vld;
    logic signed [CW-1:0] ra_lo [3];
    logic signed [CW-1:0] ra_hi [3];
    logic [2:0]           ra_par;
    logic                 ra_pmiss;
    logic signed [CW-1:0] ra_org [3];
    logic signed [CW-1:0] ra_dir [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_vld <= 1'b0;
        else          ra_vld <= d_vld[0];
        ra_par   <= t_par;
        ra_pmiss <= t_pmiss;
        for (int a = 0; a < 3; a++) begin
            ra_org[a] <= t_org[a];
            ra_dir[a] <= t_dir[a];
            if (d_q[2*a] > d_q[2*a+1]) begin
                ra_lo[a] <= d_q[2*a+1];
                ra_hi[a] <= d_q[2*a];
            end else begin
                ra_lo[a] <= d_q[2*a];
                ra_hi[a] <= d_q[2*a+1];
            end
        end
    end

    // stages B..D: narrow interval one axis per stage; a miss is sticky
    logic                 rn_vld [4];
    logic signed [CW-1:0] rn_tmin [4];
    logic signed [CW-1:0] rn_tmax [4];
    logic                 rn_miss [4];
    logic signed [CW-1:0] rn_lo [4][3];
    logic signed [CW-1:0] rn_hi [4][3];
    logic [2:0]           rn_par [4];
    logic signed [CW-1:0] rn_org [4][3];
    logic signed [CW-1:0] rn_dir [4][3];
    always_comb begin
        rn_vld[0]  = ra_vld;
        rn_tmin[0] = r_line_mode ? CMIN : '0;
        rn_tmax[0] = CW'({1'b0, r_max_dist});
        rn_miss[0] = ra_pmiss;
        rn_lo[0]   = ra_lo;
        rn_hi[0]   = ra_hi;
        rn_par[0]  = ra_par;
        rn_org[0]  = ra_org;
        rn_dir[0]  = ra_dir;
    end
    for (genvar a = 0; a < 3; a++) begin : g_ax
        logic signed [CW-1:0] n_mn, n_mx;
        always_comb begin
            n_mn = rn_tmin[a];
            n_mx = rn_tmax[a];
            if (!rn_par[a][a]) begin
                if (rn_lo[a][a] > n_mn) n_mn = rn_lo[a][a];
                if (rn_hi[a][a] < n_mx) n_mx = rn_hi[a][a];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rn_vld[a+1] <= 1'b0;
            else          rn_vld[a+1] <= rn_vld[a];
            // once missed, later axes do not matter; tmin only used on hit
            rn_miss[a+1] <= rn_miss[a] || (n_mn > n_mx);
            rn_tmin[a+1] <= n_mn;
            rn_tmax[a+1] <= n_mx;
            rn_lo[a+1]   <= rn_lo[a];
            rn_hi[a+1]   <= rn_hi[a];
            rn_par[a+1]  <= rn_par[a];
            rn_org[a+1]  <= rn_org[a];
            rn_dir[a+1]  <= rn_dir[a];
        end
    end

    // stage E: magnitude products (split into 4 partials for 32x32 limit)
    localparam int HW = (CW + 1) / 2 + 1;
    localparam int MW = 2 * HW;
    logic                 re_vld, re_hit;
    logic signed [CW-1:0] re_t;
    logic signed [CW-1:0] re_org [3];
    logic                 re_neg [3];
    logic [2*HW-1:0]      re_ll [3], re_lh [3], re_hl [3], re_hh [3];
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] x, y;
        if (!i_rst_n) re_vld <= 1'b0;
        else          re_vld <= rn_vld[3];
        re_hit <= !rn_miss[3];
        re_t   <= rn_tmin[3];
        for (int a = 0; a < 3; a++) begin
            x = rn_dir[3][a][CW-1] ? MW'(-(MW'(rn_dir[3][a]))) : MW'(rn_dir[3][a]);
            y = rn_tmin[3][CW-1] ? MW'(-(MW'(rn_tmin[3]))) : MW'(rn_tmin[3]);
            re_org[a] <= rn_org[3][a];
            re_neg[a] <= rn_dir[3][a][CW-1] ^ rn_tmin[3][CW-1];
            re_ll[a]  <= x[HW-1:0] * y[HW-1:0];
            re_lh[a]  <= x[HW-1:0] * y[MW-1:HW];
            re_hl[a]  <= x[MW-1:HW] * y[HW-1:0];
            re_hh[a]  <= x[MW-1:HW] * y[MW-1:HW];
        end
    end

    // stage F: sum partials, shift, saturate, sign
    logic                 rf_vld, rf_hit;
    logic signed [CW-1:0] rf_t;
    logic signed [CW-1:0] rf_org [3];
    logic signed [CW-1:0] rf_m [3];
    localparam logic [2*MW-1:0] SMAG = (2*MW)'(1) << (CW - 1);
    always_ff @(posedge i_clk) begin
        logic [2*MW-1:0] p, r;
        if (!i_rst_n) rf_vld <= 1'b0;
        else          rf_vld <= re_vld;
        rf_hit <= re_hit;
        rf_t   <= re_t;
        for (int a = 0; a < 3; a++) begin
            p = (2*MW)'(re_ll[a]) + ((2*MW)'(re_lh[a]) << HW)
              + ((2*MW)'(re_hl[a]) << HW) + ((2*MW)'(re_hh[a]) << (2*HW));
            r = p >> FB;
            if (r > SMAG) r = SMAG;
            rf_org[a] <= re_org[a];
            if (re_neg[a]) rf_m[a] <= CW'(-r);
            else if (r == SMAG) rf_m[a] <= CMAX;
            else rf_m[a] <= CW'(r);
        end
    end

    // stage G: add origin with saturation (zero on miss), output register
    logic                 rg_vld, rg_hit;
    logic signed [CW-1:0] rg_t;
    logic signed [CW-1:0] rg_p [3];
    always_ff @(posedge i_clk) begin
        logic signed [CW:0] s;
        if (!i_rst_n) rg_vld <= 1'b0;
        else          rg_vld <= rf_vld;
        rg_hit <= rf_hit;
        rg_t   <= rf_hit ? rf_t : '0;
        for (int a = 0; a < 3; a++) begin
            s = (CW+1)'(rf_org[a]) + (CW+1)'(rf_m[a]);
            if (!rf_hit) rg_p[a] <= '0;
            else if (s > (CW+1)'(CMAX)) rg_p[a] <= CMAX;
            else if (s < (CW+1)'(CMIN)) rg_p[a] <= CMIN;
            else rg_p[a] <= CW'(s);
        end
    end

    assign o_valid          = rg_vld;
    assign o_hit            = rg_hit;
    assign o_entry_distance = rg_t;
    assign o_point_x        = rg_p[0];
    assign o_point_y        = rg_p[1];
    assign o_point_z        = rg_p[2];

    logic unused;
    assign unused = ^{d_vld[1], d_vld[2], d_vld[3], d_vld[4], d_vld[5],
                      d_tag[1], d_tag[2], d_tag[3], d_tag[4], d_tag[5]};
endmodule
